/* hdl/assert_macros.svh */
// Assertion helpers included by the decoder's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/aifd_pkg.sv */
package aifd_pkg;

  typedef enum logic [2:0] {
    CLS_MULTIPLY  = 3'd0,
    CLS_SWI       = 3'd1,
    CLS_BRANCH    = 3'd2,
    CLS_DATA_PROC = 3'd3,
    CLS_LOAD_STORE = 3'd4,
    CLS_UNDEFINED = 3'd5
  } instr_class_e;

  // Major opcode values of instruction bits 27..25.
  localparam logic [2:0] TOP_DP_REG   = 3'b000;
  localparam logic [2:0] TOP_DP_IMM   = 3'b001;
  localparam logic [2:0] TOP_LS_IMM   = 3'b010;
  localparam logic [2:0] TOP_LS_REG   = 3'b011;
  localparam logic [2:0] TOP_UNDEF_LO = 3'b100;
  localparam logic [2:0] TOP_BRANCH   = 3'b101;
  localparam logic [2:0] TOP_UNDEF_HI = 3'b110;
  localparam logic [2:0] TOP_SWI      = 3'b111;
  localparam logic [3:0] MUL_MARK     = 4'b1001;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] address;
  } item_t;

  typedef struct packed {
    instr_class_e instr_class;
    logic [3:0]   cond;
    logic [3:0]   alu_op;
    logic [5:0]   control_bits;
    logic [3:0]   dest_reg;
    logic [3:0]   base_reg;
    logic [3:0]   operand_reg;
    logic [3:0]   shift_reg;
    logic [1:0]   shift_kind;
    logic [4:0]   shift_amount;
    logic [31:0]  immediate;
    logic [31:0]  branch_target;
  } result_t;

  // Rotates the 8-bit data immediate right by twice the 4-bit rotate field.
  function automatic logic [31:0] rot_imm(logic [7:0] val, logic [3:0] rot);
    logic [63:0] dbl;
    logic [63:0] shifted;
    dbl     = {24'd0, val, 24'd0, val};
    shifted = dbl >> {rot, 1'b0};
    return shifted[31:0];
  endfunction

endpackage

/* hdl/arm_instruction_field_decoder.sv */
// ARM32 instruction field decoder. Pulse start with an instruction word and its
// address; the decoded fields reach result_o via the item and result registers,
// with a one-cycle done_o pulse. busy stays low, so a new item is taken every cycle:
// one register captures the item, one decode pass fills the result register.
// The receiver cannot stall and must take each result in the cycle it shows.
`include "assert_macros.svh"

module arm_instruction_field_decoder
  import aifd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output result_t result_o,
  output logic    done_o
);

  item_t   item_q;
  logic    in_valid_q;
  result_t dec;
  result_t result_q;
  logic    done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_i;
    end
    if (in_valid_q) begin
      result_q <= dec;
    end
  end

  aifd_decode u_decode (
    .item_i   (item_q),
    .result_o (dec)
  );

  assign result_o = result_q;
  assign done_o   = done_q;

  `ASSERT_NEXT(a_valid_to_done, clk_i, rst_ni, in_valid_q, done_o)
  `ASSERT_ALWAYS(a_target_only_branch, clk_i, rst_ni,
    !done_o || result_o.instr_class == CLS_BRANCH || result_o.branch_target == 32'd0)
  `ASSERT_ALWAYS(a_undef_no_fields, clk_i, rst_ni,
    !done_o || result_o.instr_class != CLS_UNDEFINED
    || (result_o.dest_reg == 4'd0 && result_o.immediate == 32'd0))

endmodule

/* hdl/aifd_decode.sv */
module aifd_decode
  import aifd_pkg::*;
(
  input  item_t   item_i,
  output result_t result_o
);

  logic [31:0] w;
  logic [2:0]  top;
  logic        is_mul;
  logic [31:0] offset;

  assign w      = item_i.instruction;
  assign top    = w[27:25];
  assign is_mul = (w[27:22] == 6'd0) && (w[7:4] == MUL_MARK);
  assign offset = {{6{w[23]}}, w[23:0], 2'b00};

  always_comb begin
    result_o              = '0;
    result_o.cond         = w[31:28];
    result_o.control_bits = w[25:20];
    if (is_mul) begin
      result_o.instr_class = CLS_MULTIPLY;
      result_o.dest_reg    = w[19:16];
      result_o.base_reg    = w[15:12];
      result_o.operand_reg = w[3:0];
      result_o.shift_reg   = w[11:8];
    end else if (top == TOP_SWI) begin
      result_o.instr_class = CLS_SWI;
      result_o.immediate   = {8'd0, w[23:0]};
    end else if (top == TOP_BRANCH) begin
      result_o.instr_class   = CLS_BRANCH;
      result_o.branch_target = item_i.address + 32'd8 + offset;
    end else if (top[2:1] == TOP_DP_REG[2:1]) begin
      result_o.instr_class = CLS_DATA_PROC;
      result_o.alu_op      = w[24:21];
      result_o.dest_reg    = w[15:12];
      result_o.base_reg    = w[19:16];
      if (w[25]) begin
        result_o.immediate = rot_imm(w[7:0], w[11:8]);
      end else begin
        result_o.operand_reg = w[3:0];
        result_o.shift_kind  = w[6:5];
        if (w[4]) begin
          result_o.shift_reg = w[11:8];
        end else begin
          result_o.shift_amount = w[11:7];
        end
      end
    end else if (top[2:1] == TOP_LS_IMM[2:1]) begin
      result_o.instr_class = CLS_LOAD_STORE;
      result_o.dest_reg    = w[15:12];
      result_o.base_reg    = w[19:16];
      // For load/store the register form is the one with bit 25 set.
      if (w[25]) begin
        result_o.operand_reg  = w[3:0];
        result_o.shift_kind   = w[6:5];
        result_o.shift_amount = w[11:7];
      end else begin
        result_o.immediate = {20'd0, w[11:0]};
      end
    end else begin
      result_o.instr_class = CLS_UNDEFINED;
    end
  end

endmodule

/* verif/tb_arm_instruction_field_decoder.sv */
`timescale 1ns / 1ps

module tb_arm_instruction_field_decoder;
  import aifd_pkg::*;

  localparam int RANDOM_ITEMS = 1900;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  result_t result_o;
  logic    done_o;

  item_t   instr_queue[$];
  result_t decoded_fields_q[$];
  int      accepted_cnt = 0;
  int      err_cnt = 0;

  arm_instruction_field_decoder uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .result_o (result_o),
    .done_o   (done_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic result_t decode_word(item_t it);
    logic [31:0] w;
    logic [31:0] offset;
    logic [31:0] imm8;
    int unsigned rot;
    result_t     r;
    w = it.instruction;
    r = '0;
    r.cond         = w[31:28];
    r.control_bits = w[25:20];
    // The multiply pattern wins over whatever bits 27..25 would select.
    if (w[27:22] == 6'd0 && w[7:4] == MUL_MARK) begin
      r.instr_class = CLS_MULTIPLY;
      r.dest_reg    = w[19:16];
      r.base_reg    = w[15:12];
      r.operand_reg = w[3:0];
      r.shift_reg   = w[11:8];
    end else begin
      case (w[27:25])
        TOP_SWI: begin
          r.instr_class = CLS_SWI;
          r.immediate   = {8'd0, w[23:0]};
        end
        TOP_BRANCH: begin
          offset          = {{6{w[23]}}, w[23:0], 2'b00};
          r.instr_class   = CLS_BRANCH;
          r.branch_target = it.address + 32'd8 + offset;
        end
        TOP_DP_REG, TOP_DP_IMM: begin
          r.instr_class = CLS_DATA_PROC;
          r.alu_op      = w[24:21];
          r.dest_reg    = w[15:12];
          r.base_reg    = w[19:16];
          if (w[25]) begin
            imm8        = {24'd0, w[7:0]};
            rot         = 32'({w[11:8], 1'b0});
            // A zero rotate shifts left by 32, which yields zero, so the value stays as is.
            r.immediate = (imm8 >> rot) | (imm8 << (32 - rot));
          end else begin
            r.operand_reg = w[3:0];
            r.shift_kind  = w[6:5];
            if (w[4]) begin
              r.shift_reg = w[11:8];
            end else begin
              r.shift_amount = w[11:7];
            end
          end
        end
        TOP_LS_IMM, TOP_LS_REG: begin
          r.instr_class = CLS_LOAD_STORE;
          r.dest_reg    = w[15:12];
          r.base_reg    = w[19:16];
          if (w[25]) begin
            r.operand_reg  = w[3:0];
            r.shift_kind   = w[6:5];
            r.shift_amount = w[11:7];
          end else begin
            r.immediate = {20'd0, w[11:0]};
          end
        end
        default: begin
          r.instr_class = CLS_UNDEFINED;
        end
      endcase
    end
    return r;
  endfunction

  function automatic item_t random_instruction();
    item_t it;
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(9))
      0: begin
        w[27:22] = 6'd0;
        w[7:4]   = MUL_MARK;
      end
      1: w[27:25] = TOP_SWI;
      2: w[27:25] = TOP_BRANCH;
      3, 4: w[27:26] = TOP_DP_REG[2:1];
      5, 6: w[27:26] = TOP_LS_IMM[2:1];
      7: w[27:25] = $urandom_range(1) ? TOP_UNDEF_HI : TOP_UNDEF_LO;
      default: ;
    endcase
    it.instruction = w;
    it.address     = ($urandom_range(7) == 0) ? 32'hFFFF_FFFC : 32'($urandom());
    return it;
  endfunction

  task automatic diff_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Driver: the current item is held while busy; a new one is taken from the
  // queue only after the old one went through or while start was low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        decoded_fields_q.push_back(decode_word(item_i));
        accepted_cnt++;
      end
      if (instr_queue.size() != 0 &&
          !((accepted_cnt == 300 || accepted_cnt == 1500) &&
            decoded_fields_q.size() != 0) &&
          !(!(accepted_cnt >= 900 && accepted_cnt < 1200) &&
            $urandom_range(99) < 33)) begin
        item_i <= instr_queue.pop_front();
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (decoded_fields_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, result_o);
        err_cnt++;
      end else begin
        want = decoded_fields_q.pop_front();
        diff_field("instr_class", 32'(want.instr_class), 32'(result_o.instr_class));
        diff_field("cond", 32'(want.cond), 32'(result_o.cond));
        diff_field("alu_op", 32'(want.alu_op), 32'(result_o.alu_op));
        diff_field("control_bits", 32'(want.control_bits), 32'(result_o.control_bits));
        diff_field("dest_reg", 32'(want.dest_reg), 32'(result_o.dest_reg));
        diff_field("base_reg", 32'(want.base_reg), 32'(result_o.base_reg));
        diff_field("operand_reg", 32'(want.operand_reg), 32'(result_o.operand_reg));
        diff_field("shift_reg", 32'(want.shift_reg), 32'(result_o.shift_reg));
        diff_field("shift_kind", 32'(want.shift_kind), 32'(result_o.shift_kind));
        diff_field("shift_amount", 32'(want.shift_amount), 32'(result_o.shift_amount));
        diff_field("immediate", want.immediate, result_o.immediate);
        diff_field("branch_target", want.branch_target, result_o.branch_target);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] words[$];
    logic [31:0] addrs[$];
    item_t       it;
    words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hE03F_FF9F, 32'h0000_0090,
              32'h0040_0090, 32'hEA7F_FFFF, 32'hEB80_0000, 32'hEAFF_FFFE,
              32'hEA00_0000, 32'hE3A0_00FF, 32'hE3E0_0FFF, 32'hE3A0_04A5,
              32'hE1A0_0FE3, 32'hE1A0_0F53, 32'hE59F_0FFF, 32'hE79F_0FE3,
              32'hE7FF_FFFF, 32'h0800_0000, 32'hFDFF_FFFF, 32'h01F0_0090,
              32'hF000_0000};
    addrs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000,
              32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000,
              32'hFFFF_FFFC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
              32'h8000_0000};
    foreach (words[i]) begin
      it.instruction = words[i];
      it.address     = addrs[i];
      instr_queue.push_back(it);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      instr_queue.push_back(random_instruction());
    end

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (instr_queue.size() != 0 || start || decoded_fields_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("arm_instruction_field_decoder verification clean");
    end else begin
      $display("arm_instruction_field_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("arm_instruction_field_decoder verification failed");
    $finish;
  end

endmodule
